/* src/dmte_pkg.sv */
// shared types and constants for the debounced menu threshold editor
package dmte_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int TimeW    = 32;
	localparam int DbW      = 16;
	localparam int TempW    = 12;
	localparam int HumW     = 10;
	localparam int LightW   = 10;

	// register indexes on the config port
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_MS = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_TEMP_MIN    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TEMP_MAX    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_HUM_MIN     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_HUM_MAX     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_LIGHT_MIN   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_LIGHT_MAX   = 3'd6;

	localparam logic [DbW-1:0]           DEBOUNCE_RST  = 16'd50;
	localparam logic signed [TempW-1:0]  TEMP_MIN_RST  = -12'sd100;
	localparam logic signed [TempW-1:0]  TEMP_MAX_RST  = 12'sd500;
	localparam logic [HumW-1:0]          HUM_MIN_RST   = 10'd0;
	localparam logic [HumW-1:0]          HUM_MAX_RST   = 10'd1000;
	localparam logic [LightW-1:0]        LIGHT_MIN_RST = 10'd0;
	localparam logic [LightW-1:0]        LIGHT_MAX_RST = 10'd1023;

	typedef enum logic [1:0] {
		MODE_VIEW  = 2'd0,
		MODE_TEMP  = 2'd1,
		MODE_HUM   = 2'd2,
		MODE_LIGHT = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [TempW-1:0]  temp_limit;
		logic [HumW-1:0]          hum_limit;
		logic [LightW-1:0]        light_limit;
		logic                     save_strobe;
	} result_t;

endpackage

/* src/dmte_in_if.sv */
// input channel: timestamp and raw button levels
interface dmte_in_if import dmte_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TimeW-1:0] now_ms;
	logic             menu_level;
	logic             up_level;
	logic             down_level;

	modport source (output valid, now_ms, menu_level, up_level, down_level, input ready);
	modport sink (input valid, now_ms, menu_level, up_level, down_level, output ready);
endinterface

/* src/dmte_out_if.sv */
// output channel: mode, thresholds and save strobe
interface dmte_out_if import dmte_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic signed [TempW-1:0] temp_limit;
	logic [HumW-1:0]         hum_limit;
	logic [LightW-1:0]       light_limit;
	logic                    save_strobe;

	modport source (output valid, mode, temp_limit, hum_limit, light_limit, save_strobe,
		input ready);
	modport sink (input valid, mode, temp_limit, hum_limit, light_limit, save_strobe,
		output ready);
endinterface

/* src/dmte_debounce.sv */
// timestamp debouncer for one active-low button
module dmte_debounce import dmte_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample,
	input  logic             level,
	input  logic [TimeW-1:0] now_ms,
	input  logic [DbW-1:0]   debounce_ms,
	output logic             pressed
);

	logic             last_q;
	logic             stable_q;
	logic [TimeW-1:0] change_time_q;

	logic             changed;
	logic [TimeW-1:0] chg_time;
	logic [TimeW-1:0] elapsed;
	logic             settled;
	logic             flip;

	always_comb begin
		changed  = level != last_q;
		chg_time = changed ? now_ms : change_time_q;
		// wraps modulo 2^32
		elapsed  = now_ms - chg_time;
		settled  = elapsed >= {{(TimeW-DbW){1'b0}}, debounce_ms};
		flip     = settled && (level != stable_q);
		pressed  = sample && flip && !level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q        <= 1'b1;
			stable_q      <= 1'b1;
			change_time_q <= '0;
		end else if (sample) begin
			last_q        <= level;
			change_time_q <= chg_time;
			if (flip) begin
				stable_q <= level;
			end
		end
	end

endmodule

/* src/debounced_menu_threshold_editor_unit.sv */
// top level: debounced three-button menu that edits three thresholds
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   now_ms, menu_level, up_level, down_level
//  out_ch   out  valid/ready   mode, temp_limit, hum_limit, light_limit, save_strobe
//  cfg      in   cfg_we        cfg_index, cfg_data (write only)
//
// one item per cycle while in_ch.ready is high; state is updated in the cycle an
// item is taken and its result is registered into a two-entry output buffer
// in_ch.ready drops only while both buffer entries hold untaken results
// reset returns to display mode, buttons released, thresholds zero and
// config registers at their defaults; no clearing pass
module debounced_menu_threshold_editor_unit import dmte_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	dmte_in_if.sink             in_ch,
	dmte_out_if.source          out_ch,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	// config registers
	logic [DbW-1:0]          debounce_q;
	logic signed [TempW-1:0] temp_min_q;
	logic signed [TempW-1:0] temp_max_q;
	logic [HumW-1:0]         hum_min_q;
	logic [HumW-1:0]         hum_max_q;
	logic [LightW-1:0]       light_min_q;
	logic [LightW-1:0]       light_max_q;

	// editor state
	mode_t                   mode_q;
	logic signed [TempW-1:0] temp_q;
	logic [HumW-1:0]         hum_q;
	logic [LightW-1:0]       light_q;

	// output buffer
	result_t    buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	logic                    in_acc;
	logic                    out_acc;
	logic                    menu_press;
	logic                    up_press;
	logic                    down_press;
	logic                    edit_en;
	logic                    save;
	mode_t                   mode_nxt;
	logic signed [TempW-1:0] temp_up;
	logic signed [TempW-1:0] temp_nxt;
	logic [HumW-1:0]         hum_up;
	logic [HumW-1:0]         hum_nxt;
	logic [LightW-1:0]       light_up;
	logic [LightW-1:0]       light_nxt;
	result_t                 res;

	assign in_ch.ready = cnt_q != 2'd2;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_ch.valid = cnt_q != 2'd0;
	assign out_acc     = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			temp_min_q  <= TEMP_MIN_RST;
			temp_max_q  <= TEMP_MAX_RST;
			hum_min_q   <= HUM_MIN_RST;
			hum_max_q   <= HUM_MAX_RST;
			light_min_q <= LIGHT_MIN_RST;
			light_max_q <= LIGHT_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_MS: debounce_q  <= cfg_data[DbW-1:0];
				REG_TEMP_MIN:    temp_min_q  <= cfg_data[TempW-1:0];
				REG_TEMP_MAX:    temp_max_q  <= cfg_data[TempW-1:0];
				REG_HUM_MIN:     hum_min_q   <= cfg_data[HumW-1:0];
				REG_HUM_MAX:     hum_max_q   <= cfg_data[HumW-1:0];
				REG_LIGHT_MIN:   light_min_q <= cfg_data[LightW-1:0];
				REG_LIGHT_MAX:   light_max_q <= cfg_data[LightW-1:0];
				default: ;
			endcase
		end
	end

	dmte_debounce u_menu (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (in_acc),
		.level       (in_ch.menu_level),
		.now_ms      (in_ch.now_ms),
		.debounce_ms (debounce_q),
		.pressed     (menu_press)
	);

	// up and down are only sampled when the new mode is an edit mode
	dmte_debounce u_up (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (in_acc && edit_en),
		.level       (in_ch.up_level),
		.now_ms      (in_ch.now_ms),
		.debounce_ms (debounce_q),
		.pressed     (up_press)
	);

	dmte_debounce u_down (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (in_acc && edit_en),
		.level       (in_ch.down_level),
		.now_ms      (in_ch.now_ms),
		.debounce_ms (debounce_q),
		.pressed     (down_press)
	);

	always_comb begin
		mode_nxt = mode_q;
		save     = 1'b0;
		if (menu_press) begin
			if (mode_q == MODE_LIGHT) begin
				mode_nxt = MODE_VIEW;
				save     = 1'b1;
			end else begin
				mode_nxt = mode_t'(mode_q + 2'd1);
			end
		end
	end

	assign edit_en = mode_nxt != MODE_VIEW;

	always_comb begin
		// up is applied first, then down on the result
		temp_up   = (up_press && mode_nxt == MODE_TEMP && temp_q < temp_max_q)
			? temp_q + 12'sd1 : temp_q;
		temp_nxt  = (down_press && mode_nxt == MODE_TEMP && temp_up > temp_min_q)
			? temp_up - 12'sd1 : temp_up;
		hum_up    = (up_press && mode_nxt == MODE_HUM && hum_q < hum_max_q)
			? hum_q + 10'd1 : hum_q;
		hum_nxt   = (down_press && mode_nxt == MODE_HUM && hum_up > hum_min_q)
			? hum_up - 10'd1 : hum_up;
		light_up  = (up_press && mode_nxt == MODE_LIGHT && light_q < light_max_q)
			? light_q + 10'd1 : light_q;
		light_nxt = (down_press && mode_nxt == MODE_LIGHT && light_up > light_min_q)
			? light_up - 10'd1 : light_up;

		res.mode        = mode_nxt;
		res.temp_limit  = temp_nxt;
		res.hum_limit   = hum_nxt;
		res.light_limit = light_nxt;
		res.save_strobe = save;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_VIEW;
			temp_q  <= '0;
			hum_q   <= '0;
			light_q <= '0;
		end else if (in_acc) begin
			mode_q  <= mode_nxt;
			temp_q  <= temp_nxt;
			hum_q   <= hum_nxt;
			light_q <= light_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (out_acc) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({in_acc, out_acc})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	assign out_ch.mode        = buf_q[rd_ptr_q].mode;
	assign out_ch.temp_limit  = buf_q[rd_ptr_q].temp_limit;
	assign out_ch.hum_limit   = buf_q[rd_ptr_q].hum_limit;
	assign out_ch.light_limit = buf_q[rd_ptr_q].light_limit;
	assign out_ch.save_strobe = buf_q[rd_ptr_q].save_strobe;

endmodule
